// ===== rtl/lfr_pkg.sv =====
// Shared types and constants for the letter frequency ranker.
// Holds the request/result structs, command codes and the controller command bundle.
// No dependencies.
package lfr_pkg;

  localparam int unsigned NUM_BINS     = 27;
  localparam int unsigned COUNT_WIDTH  = 32;
  localparam int unsigned IDX_W        = $clog2(NUM_BINS);
  localparam int unsigned BIN_INDEX_W  = 5;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned OUT_COUNT_W  = 32;
  localparam int unsigned CFG_ADDR_W   = 1;

  localparam logic [BYTE_W-1:0] BASE_LETTER_RST = 8'd65;
  localparam logic [BYTE_W-1:0] EXT_LEAD_RST    = 8'd195;

  typedef enum logic [1:0] {
    CMD_COUNT = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_RANK  = 2'd2,
    CMD_NONE  = 2'd3
  } command_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_BASE_LETTER = 1'b0,
    CFG_EXT_LEAD    = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]        command;
    logic [BYTE_W-1:0] byte_value;
  } req_t;

  typedef struct packed {
    logic [BIN_INDEX_W-1:0] bin_index;
    logic [BYTE_W-1:0]      letter_code;
    logic [OUT_COUNT_W-1:0] bin_count;
    logic                   last_of_run;
  } rsp_t;

  // Controller to datapath command bundle.
  typedef struct packed {
    logic             count_en;
    logic             clear_en;
    logic             rank_init;
    logic             scan_en;
    logic [IDX_W-1:0] scan_idx;
    logic             scan_first;
    logic             scan_last;
    logic             run_last;
  } ctrl_cmd_t;

endpackage

// ===== rtl/lfr_ctrl.sv =====
// Controller for the letter frequency ranker: accepts requests and sequences the rank scan.
// Depends on lfr_pkg.
module lfr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        command_i,
  output lfr_pkg::ctrl_cmd_t cmd_o
);
  import lfr_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_e;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BINS - 1);

  state_e           state_q, state_d;
  logic [IDX_W-1:0] scan_idx_q, scan_idx_d;
  logic [IDX_W-1:0] run_idx_q, run_idx_d;
  logic             accept;

  assign busy   = (state_q == ST_SCAN);
  assign accept = start && !busy;

  always_comb begin
    state_d    = state_q;
    scan_idx_d = scan_idx_q;
    run_idx_d  = run_idx_q;

    cmd_o            = '0;
    cmd_o.scan_idx   = scan_idx_q;
    cmd_o.scan_first = (scan_idx_q == '0);
    cmd_o.scan_last  = (scan_idx_q == LAST_IDX);
    cmd_o.run_last   = (run_idx_q == LAST_IDX);

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (command_i)
            CMD_COUNT: cmd_o.count_en = 1'b1;
            CMD_CLEAR: cmd_o.clear_en = 1'b1;
            CMD_RANK: begin
              cmd_o.rank_init = 1'b1;
              scan_idx_d      = '0;
              run_idx_d       = '0;
              state_d         = ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        cmd_o.scan_en = 1'b1;
        if (scan_idx_q == LAST_IDX) begin
          // one bin picked: restart the scan for the next result
          scan_idx_d = '0;
          run_idx_d  = run_idx_q + 1'b1;
          if (run_idx_q == LAST_IDX) begin
            state_d = ST_IDLE;
          end
        end else begin
          scan_idx_d = scan_idx_q + 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      scan_idx_q <= '0;
      run_idx_q  <= '0;
    end else begin
      state_q    <= state_d;
      scan_idx_q <= scan_idx_d;
      run_idx_q  <= run_idx_d;
    end
  end

endmodule

// ===== rtl/lfr_datapath.sv =====
// Datapath for the letter frequency ranker: config registers, bin counters,
// ranked flags, running best-bin search and the result register. Depends on lfr_pkg.
module lfr_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lfr_pkg::ctrl_cmd_t            cmd_i,
  input  logic [lfr_pkg::BYTE_W-1:0]    byte_value_i,
  input  logic                          cfg_we_i,
  input  logic [lfr_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [lfr_pkg::BYTE_W-1:0]    cfg_wdata_i,
  output logic                          rsp_valid_o,
  output lfr_pkg::rsp_t                 rsp_o
);
  import lfr_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  logic [BYTE_W-1:0]      base_letter_q, ext_lead_q;
  logic [COUNT_WIDTH-1:0] cnt_q [NUM_BINS];
  logic [COUNT_WIDTH-1:0] cnt_d [NUM_BINS];
  logic [NUM_BINS-1:0]    ranked_q, ranked_d;

  logic [BYTE_W-1:0]      offset;
  logic                   hit_valid;
  logic [IDX_W-1:0]       hit_idx;

  logic [IDX_W-1:0]       best_idx_q, best_idx_d;
  logic [COUNT_WIDTH-1:0] best_cnt_q, best_cnt_d;
  logic                   have_q, have_d;
  logic [COUNT_WIDTH-1:0] scan_cnt;
  logic                   have_now, take;

  logic                   rsp_valid_q, rsp_valid_d;
  rsp_t                   rsp_q, rsp_d;

  // Config registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_letter_q <= BASE_LETTER_RST;
      ext_lead_q    <= EXT_LEAD_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_BASE_LETTER: base_letter_q <= cfg_wdata_i;
        CFG_EXT_LEAD:    ext_lead_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Bin decode: the lead byte wins over the letter range.
  assign offset = byte_value_i - base_letter_q;
  always_comb begin
    if (byte_value_i == ext_lead_q) begin
      hit_valid = 1'b1;
      hit_idx   = IDX_W'(NUM_BINS - 1);
    end else begin
      hit_valid = (32'(offset) < NUM_BINS);
      hit_idx   = IDX_W'(offset);
    end
  end

  // Per-bin saturating counters.
  always_comb begin
    for (int i = 0; i < NUM_BINS; i++) begin
      cnt_d[i] = cnt_q[i];
      if (cmd_i.clear_en) begin
        cnt_d[i] = '0;
      end else if (cmd_i.count_en && hit_valid && (hit_idx == IDX_W'(i))
                   && (cnt_q[i] != COUNT_MAX)) begin
        cnt_d[i] = cnt_q[i] + 1'b1;
      end
    end
  end

  // Running search for the largest unranked count; strict compare keeps the lower index on ties.
  assign scan_cnt = cnt_q[cmd_i.scan_idx];
  assign have_now = cmd_i.scan_first ? 1'b0 : have_q;
  assign take     = !ranked_q[cmd_i.scan_idx] && (!have_now || (scan_cnt > best_cnt_q));

  always_comb begin
    best_idx_d  = best_idx_q;
    best_cnt_d  = best_cnt_q;
    have_d      = have_q;
    ranked_d    = ranked_q;
    rsp_valid_d = 1'b0;
    rsp_d       = rsp_q;

    if (cmd_i.rank_init) begin
      ranked_d = '0;
    end

    if (cmd_i.scan_en) begin
      have_d = have_now || take;
      if (take) begin
        best_idx_d = cmd_i.scan_idx;
        best_cnt_d = scan_cnt;
      end
      if (cmd_i.scan_last) begin
        ranked_d[best_idx_d] = 1'b1;
        rsp_valid_d          = 1'b1;
        rsp_d.bin_index      = BIN_INDEX_W'(best_idx_d);
        rsp_d.letter_code    = BYTE_W'(best_idx_d) + base_letter_q;
        rsp_d.bin_count      = OUT_COUNT_W'(best_cnt_d);
        rsp_d.last_of_run    = cmd_i.run_last;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BINS; i++) begin
        cnt_q[i] <= '0;
      end
      ranked_q    <= '0;
      have_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      for (int i = 0; i < NUM_BINS; i++) begin
        cnt_q[i] <= cnt_d[i];
      end
      ranked_q    <= ranked_d;
      have_q      <= have_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_idx_q <= best_idx_d;
    best_cnt_q <= best_cnt_d;
    rsp_q      <= rsp_d;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

// ===== rtl/letter_frequency_ranker.sv =====
// Top level of the letter frequency ranker: controller plus datapath.
// Depends on lfr_pkg, lfr_ctrl and lfr_datapath.
//
// Usage:
//   Request channel: a request (command, byte_value) is taken at a rising edge
//   with start high and busy low.
//     Count request: counts byte_value into its letter bin, so a byte stream
//     may be fed at one byte per clock while busy is low.
//     Clear request: zeroes every bin.
//     Rank request: raises busy and emits all bins in descending count order,
//     ties to the lower bin index. Each result is found by a scan that reads
//     one bin per cycle through the counter read mux. busy drops as the last
//     result is registered.
//   Result channel: rsp_valid_o is a one-cycle strobe with rsp_o; the receiver
//   cannot stall it. last_of_run marks the final bin.
//   Config channel: cfg_ready_o is always high; write only while idle.
//   Reset: all counts zero, base letter 65, extended lead byte 195.
module letter_frequency_ranker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  lfr_pkg::req_t                  req_i,
  output logic                           rsp_valid_o,
  output lfr_pkg::rsp_t                  rsp_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lfr_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [lfr_pkg::BYTE_W-1:0]     cfg_wdata_i
);
  import lfr_pkg::*;

  ctrl_cmd_t cmd;

  // Config writes go straight into the config registers, so never hold them off.
  assign cfg_ready_o = 1'b1;

  lfr_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .command_i (req_i.command),
    .cmd_o     (cmd)
  );

  lfr_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .byte_value_i (req_i.byte_value),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .rsp_valid_o  (rsp_valid_o),
    .rsp_o        (rsp_o)
  );

endmodule
